FILE: rtl/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

    // Width of the wide operand kinds
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for the largest wide magnitude
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIG_MAX    = (VALUE_BITS > 4 * DEC_DIGITS) ? VALUE_BITS : 4 * DEC_DIGITS;
    // Digit register width: a multiple of 12 so octal, hex and binary groups all align
    localparam int DIG_W      = ((DIG_MAX + 11) / 12) * 12;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W     = $clog2(DIG_W + 1);

    localparam logic [LEFT_W-1:0] POS_HEX = LEFT_W'(DIG_W / 4);
    localparam logic [LEFT_W-1:0] POS_OCT = LEFT_W'(DIG_W / 3);
    localparam logic [LEFT_W-1:0] POS_BIN = LEFT_W'(DIG_W);

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef enum logic [2:0] {
        FUNC_U16  = 3'd0,
        FUNC_S16  = 3'd1,
        FUNC_UWID = 3'd2,
        FUNC_SWID = 3'd3,
        FUNC_PTR  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_OCT = 2'd2,
        BASE_BIN = 2'd3
    } t_base;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_PFX,
        ST_DIGIT
    } t_state;

    // Map a digit value to its lower-case ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_LC_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/integer_to_ascii_radix_printer.sv
`default_nettype none

// Prints one integer as ASCII, most significant character first, one character per
// o_strobe pulse, with o_last_char on the final one; the receiver cannot stall, so each
// character is valid for exactly one cycle. An item is taken when i_start is high and
// o_busy is low, and o_busy stays high until the last character has gone out. Decimal
// items first run a shift-and-add-3 binary-to-BCD conversion over all VALUE_BITS bits;
// all bases then drop leading zero digit positions (the digit register is DIG_W bits wide:
// 12 hex or decimal positions, 16 octal, 48 binary at 32 bits), then emit the sign or
// prefix and then the digits. Every dropped position is one digit fewer to emit. An
// undefined operand kind is taken without raising o_busy and prints nothing.
module integer_to_ascii_radix_printer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [2:0]  i_func,
    input  wire logic [31:0] i_value,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_wr_data,
    output logic             o_busy,
    output logic             o_strobe,
    output logic [7:0]       o_char_code,
    output logic             o_last_char
);
    import itoa_pkg::*;

    localparam int VB = VALUE_BITS;

    t_state              r_state, n_state;
    logic [1:0]          r_number_base;
    t_base               r_base, n_base;
    logic [DIG_W-1:0]    r_dig, n_dig;
    logic [VB-1:0]       r_bin, n_bin;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [7:0]          r_pfx0, n_pfx0;
    logic [7:0]          r_pfx1, n_pfx1;
    logic [1:0]          r_npfx, n_npfx;

    logic [3:0]          top_digit;
    logic [DIG_W-1:0]    dig_shifted;
    logic [DIG_W-1:0]    dig_adj;
    logic [VB+31:0]      value_ext;
    logic [VB-1:0]       wide_raw;
    logic [VB-1:0]       mag;
    logic [15:0]         neg16;
    t_base               eff_base;
    logic                is_neg;

    // Hold the base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= 2'd0;
        end else if (i_cfg_wr_en) begin
            r_number_base <= i_cfg_wr_data;
        end
    end

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_npfx  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_npfx  <= n_npfx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_dig  <= n_dig;
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_pfx0 <= n_pfx0;
        r_pfx1 <= n_pfx1;
    end

    // Pick the top digit and the digit register after one digit shift
    always_comb begin
        case (r_base)
            BASE_OCT: begin
                top_digit   = {1'b0, r_dig[DIG_W-1 -: 3]};
                dig_shifted = r_dig << 3;
            end
            BASE_BIN: begin
                top_digit   = {3'b000, r_dig[DIG_W-1]};
                dig_shifted = r_dig << 1;
            end
            default: begin
                top_digit   = r_dig[DIG_W-1 -: 4];
                dig_shifted = r_dig << 4;
            end
        endcase
    end

    // Add 3 to every BCD nibble of 5 or more before the next shift
    always_comb begin
        for (int i = 0; i < DIG_W / 4; i++) begin
            if (r_dig[i*4 +: 4] >= 4'd5) begin
                dig_adj[i*4 +: 4] = r_dig[i*4 +: 4] + 4'd3;
            end else begin
                dig_adj[i*4 +: 4] = r_dig[i*4 +: 4];
            end
        end
    end

    // Operand decode: magnitude, sign and effective base
    always_comb begin
        value_ext = {{VB{1'b0}}, i_value};
        wide_raw  = value_ext[VB-1:0];
        neg16     = ~i_value[15:0] + 16'd1;
        eff_base  = (i_func == FUNC_PTR) ? BASE_HEX : t_base'(r_number_base);
        is_neg    = 1'b0;
        if (i_func == FUNC_U16 || i_func == FUNC_S16) begin
            if (i_func == FUNC_S16 && eff_base == BASE_DEC && i_value[15]) begin
                is_neg = 1'b1;
                mag    = VB'(neg16);
            end else begin
                mag    = VB'(i_value[15:0]);
            end
        end else begin
            if (i_func == FUNC_SWID && eff_base == BASE_DEC && wide_raw[VB-1]) begin
                is_neg = 1'b1;
                mag    = ~wide_raw + VB'(1);
            end else begin
                mag    = wide_raw;
            end
        end
    end

    // Sequencer: next state, datapath updates and outputs
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_dig       = r_dig;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_pfx0      = r_pfx0;
        n_pfx1      = r_pfx1;
        n_npfx      = r_npfx;
        o_strobe    = 1'b0;
        o_char_code = 8'd0;
        o_last_char = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_start && i_func <= FUNC_PTR) begin
                    n_base = eff_base;
                    n_pfx0 = CHAR_ZERO;
                    n_pfx1 = CHAR_ZERO;
                    case (eff_base)
                        BASE_HEX: begin
                            n_left  = POS_HEX;
                            n_pfx1  = CHAR_X;
                            n_npfx  = 2'd2;
                        end
                        BASE_OCT: begin
                            n_left  = POS_OCT;
                            n_npfx  = 2'd1;
                        end
                        BASE_BIN: begin
                            n_left  = POS_BIN;
                            n_pfx1  = CHAR_B;
                            n_npfx  = 2'd2;
                        end
                        default: begin
                            n_left  = POS_HEX;
                            n_pfx0  = CHAR_MINUS;
                            n_npfx  = is_neg ? 2'd1 : 2'd0;
                        end
                    endcase
                    if (eff_base == BASE_DEC) begin
                        n_bin   = mag;
                        n_dig   = '0;
                        n_cnt   = CNT_W'(VB);
                        n_state = ST_CONV;
                    end else begin
                        n_dig   = DIG_W'(mag);
                        n_state = ST_SKIP;
                    end
                end
            end
            ST_CONV: begin
                // Shift one binary bit into the BCD digits
                n_dig = {dig_adj[DIG_W-2:0], r_bin[VB-1]};
                n_bin = r_bin << 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zero digits, keep at least one
                if (top_digit == 4'd0 && r_left > LEFT_W'(1)) begin
                    n_dig  = dig_shifted;
                    n_left = r_left - LEFT_W'(1);
                end else if (r_npfx != 2'd0) begin
                    n_state = ST_PFX;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_PFX: begin
                o_strobe    = 1'b1;
                o_char_code = r_pfx0;
                n_pfx0      = r_pfx1;
                n_npfx      = r_npfx - 2'd1;
                if (r_npfx == 2'd1) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                o_strobe    = 1'b1;
                o_char_code = digit_char(top_digit);
                o_last_char = (r_left == LEFT_W'(1));
                n_dig       = dig_shifted;
                n_left      = r_left - LEFT_W'(1);
                if (r_left == LEFT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/itoa_checker.sv
`default_nettype none

module itoa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic [2:0] i_func,
    input wire logic       o_busy,
    input wire logic       o_strobe,
    input wire logic       o_last_char
);
    import itoa_pkg::*;

    // A defined transaction makes the block busy on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_func <= FUNC_PTR) |=> o_busy)
        else $error("defined transaction did not raise busy");

    // An undefined operand kind leaves the block idle
    a_bad_func_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_func > FUNC_PTR) |=> !o_busy)
        else $error("undefined operand kind raised busy");

    // Characters only come out while busy, never right after an idle cycle
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |=> !o_strobe)
        else $error("character emitted right after idle");

    // The last character ends the transaction
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_char) |=> !o_busy)
        else $error("busy stayed high after the last character");

    // The last flag is only shown with a character
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_char |-> (o_strobe && o_busy))
        else $error("last flag without a character");

endmodule

bind integer_to_ascii_radix_printer itoa_checker u_itoa_checker (.*);

`default_nettype wire

FILE: sim/tb_integer_to_ascii_radix_printer.sv
`timescale 1ns / 100ps

module tb_integer_to_ascii_radix_printer;

    import itoa_pkg::*;

    // Operand kinds the block does not define
    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS  = 200;
    localparam int NUM_PHASES    = 6;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 1000;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char_exp;

    typedef struct {
        t_base       base;
        logic [2:0]  func;
        logic [31:0] value;
        bit          typed;
        string       text;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [2:0]  i_func;
    logic [31:0] i_value;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_wr_data;
    logic        o_busy;
    logic        o_strobe;
    logic [7:0]  o_char_code;
    logic        o_last_char;

    t_char_exp   expected_chars[$];
    t_row        directed_rows[$];
    t_base       cur_base;
    int          fail_count;
    int          stall_cycles;

    integer_to_ascii_radix_printer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_busy        (o_busy),
        .o_strobe      (o_strobe),
        .o_char_code   (o_char_code),
        .o_last_char   (o_last_char)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Push one character of expected text
    function automatic void push_char(input logic [7:0] code, input logic last);
        t_char_exp e;
        e.code = code;
        e.last = last;
        expected_chars.push_back(e);
    endfunction

    // Work out the text the block prints for one operand
    function automatic void render_number(input logic [2:0] f, input logic [31:0] v,
                                          input t_base b);
        int          width;
        bit          is_signed;
        logic [63:0] radix;
        logic [63:0] mask;
        logic [63:0] mag;
        logic [3:0]  d;
        logic [7:0]  digs[64];
        int          nd;
        if (f > FUNC_PTR) begin
            return;
        end
        width     = (f == FUNC_U16 || f == FUNC_S16) ? 16 : VALUE_BITS;
        is_signed = (f == FUNC_S16 || f == FUNC_SWID);
        case (b)
            BASE_HEX: radix = 64'd16;
            BASE_OCT: radix = 64'd8;
            BASE_BIN: radix = 64'd2;
            default:  radix = 64'd10;
        endcase
        if (f == FUNC_PTR) begin
            radix = 64'd16;
        end
        mask = (64'd1 << width) - 64'd1;
        mag  = {32'd0, v} & mask;
        // Sign and magnitude only in decimal
        if (is_signed && radix == 64'd10 && mag[width-1]) begin
            push_char("-", 1'b0);
            mag = (~mag + 64'd1) & mask;
        end
        if (radix == 64'd16) begin
            push_char("0", 1'b0);
            push_char("x", 1'b0);
        end else if (radix == 64'd2) begin
            push_char("0", 1'b0);
            push_char("b", 1'b0);
        end else if (radix == 64'd8) begin
            push_char("0", 1'b0);
        end
        nd = 0;
        if (mag == 64'd0) begin
            digs[0] = "0";
            nd      = 1;
        end
        while (mag != 64'd0) begin
            d        = 4'(mag % radix);
            digs[nd] = (d < 4'd10) ? (8'h30 + 8'(d)) : (8'h61 + 8'(d) - 8'd10);
            nd++;
            mag      = mag / radix;
        end
        for (int i = nd - 1; i >= 0; i--) begin
            push_char(digs[i], i == 0);
        end
    endfunction

    // Push typed expected text, flagging its final character
    function automatic void push_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            push_char(text[i], i == text.len() - 1);
        end
    endfunction

    function automatic void add_row(input t_base b, input logic [2:0] f, input logic [31:0] v,
                                    input bit typed, input string text);
        t_row r;
        r.base  = b;
        r.func  = f;
        r.value = v;
        r.typed = typed;
        r.text  = text;
        directed_rows.push_back(r);
    endfunction

    // Pick an operand with a bias toward the edges
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return {16'($urandom), ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF};
            4: return 32'($urandom_range(0, 20));
            5: return ~32'($urandom_range(0, 20));
            default: return $urandom;
        endcase
    endfunction

    // Hold start low until every expected character has come out
    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Write the base register once the block is idle
    task automatic write_base_reg(input t_base b);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= b;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_base = b;
    endtask

    // Issue one transaction and record what it should print
    task automatic send_item(input logic [2:0] f, input logic [31:0] v, input bit typed,
                             input string text, input bit allow_idle);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_func  <= f;
        i_value <= v;
        do @(posedge i_clk); while (o_busy);
        if (typed) begin
            push_text(text);
        end else begin
            render_number(f, v, cur_base);
        end
    endtask

    // Compare every strobed character with the oldest expectation
    always @(posedge i_clk) begin
        t_char_exp e;
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character: char_code %h last_char %b",
                       o_char_code, o_last_char);
                fail_count++;
            end else begin
                e = expected_chars.pop_front();
                if (o_char_code !== e.code) begin
                    $error("char_code mismatch: expected %h, actual %h", e.code, o_char_code);
                    fail_count++;
                end
                if (o_last_char !== e.last) begin
                    $error("last_char mismatch: expected %b, actual %b", e.last, o_last_char);
                    fail_count++;
                end
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main stimulus
    initial begin
        int   count;
        int   phase_end;
        t_base b;
        logic [2:0] f;
        cur_base      = BASE_DEC;
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_func        <= FUNC_U16;
        i_value       <= 32'd0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= BASE_DEC;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: extremes, every kind, every base
        add_row(BASE_DEC, FUNC_U16,  32'd0,          1, "0");
        add_row(BASE_DEC, FUNC_U16,  32'h0000_FFFF,  1, "65535");
        add_row(BASE_DEC, FUNC_U16,  32'hABCD_1234,  1, "4660");
        add_row(BASE_DEC, FUNC_S16,  32'h0000_8000,  1, "-32768");
        add_row(BASE_DEC, FUNC_S16,  32'h0000_7FFF,  1, "32767");
        add_row(BASE_DEC, FUNC_S16,  32'hFFFF_FFFF,  1, "-1");
        add_row(BASE_DEC, FUNC_UWID, 32'hFFFF_FFFF,  1, "4294967295");
        add_row(BASE_DEC, FUNC_SWID, 32'h8000_0000,  1, "-2147483648");
        add_row(BASE_DEC, FUNC_SWID, 32'd0,          1, "0");
        add_row(BASE_DEC, FUNC_PTR,  32'hDEAD_BEEF,  1, "0xdeadbeef");
        add_row(BASE_DEC, FUNC_RSVD5, 32'h1234_5678, 1, "");
        add_row(BASE_DEC, FUNC_RSVD6, 32'hFFFF_FFFF, 1, "");
        add_row(BASE_DEC, FUNC_RSVD7, 32'd0,         1, "");
        add_row(BASE_DEC, FUNC_UWID, 32'd12345,      0, "");
        add_row(BASE_HEX, FUNC_S16,  32'h0000_8000,  1, "0x8000");
        add_row(BASE_HEX, FUNC_SWID, 32'hFFFF_FFFF,  1, "0xffffffff");
        add_row(BASE_HEX, FUNC_U16,  32'd0,          1, "0x0");
        add_row(BASE_HEX, FUNC_UWID, 32'h0123_ABCD,  0, "");
        add_row(BASE_OCT, FUNC_UWID, 32'hFFFF_FFFF,  1, "037777777777");
        add_row(BASE_OCT, FUNC_S16,  32'h0000_FFFF,  1, "0177777");
        add_row(BASE_OCT, FUNC_U16,  32'd0,          1, "00");
        add_row(BASE_BIN, FUNC_U16,  32'd1,          1, "0b1");
        add_row(BASE_BIN, FUNC_S16,  32'h0000_8000,  1, "0b1000000000000000");
        add_row(BASE_BIN, FUNC_PTR,  32'd0,          1, "0x0");
        add_row(BASE_BIN, FUNC_UWID, 32'hFFFF_FFFF,  0, "");
        add_row(BASE_DEC, FUNC_SWID, 32'h7FFF_FFFF,  1, "2147483647");

        // The first rows run on the base register's reset value
        foreach (directed_rows[i]) begin
            if (directed_rows[i].base != cur_base) begin
                write_base_reg(directed_rows[i].base);
            end
            send_item(directed_rows[i].func, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].text, 1'b1);
        end

        // Random phases, each under a base written at its start; the last one runs back to back
        count = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: b = BASE_BIN;
                1: b = BASE_HEX;
                2: b = BASE_OCT;
                3: b = BASE_DEC;
                default: b = t_base'($urandom_range(0, 3));
            endcase
            write_base_reg(b);
            phase_end = (p + 1) * RANDOM_ITEMS / NUM_PHASES;
            while (count < phase_end) begin
                if ($urandom_range(0, 19) == 0) begin
                    f = 3'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
                end else begin
                    f = 3'($urandom_range(FUNC_U16, FUNC_PTR));
                    count++;
                end
                if (p != NUM_PHASES - 1 && $urandom_range(0, 24) == 0) begin
                    drain_results();
                end
                send_item(f, pick_value(), 1'b0, "", p != NUM_PHASES - 1);
            end
        end

        // Let the last characters come out
        i_start <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/itoa_pkg.sv
rtl/integer_to_ascii_radix_printer.sv
rtl/itoa_checker.sv
sim/tb_integer_to_ascii_radix_printer.sv
